[hw/rtl/thpid_pkg.sv]
// Package for the heading PID regulator: field widths, register indexes,
// reset values and fixed-point constants. No dependencies.
`default_nettype none

package thpid_pkg;

  localparam int HEAD_W     = 24;
  localparam int ELAPSED_W  = 16;
  localparam int DRIVE_W    = 15;
  localparam int MV_W       = 14;
  localparam int GAIN_W     = 20;
  localparam int SCALE_W    = 16;
  localparam int ACC_W      = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int SUM_W      = 62;
  localparam int CNT_W      = 5;
  localparam int GOAL_BITS  = 16;
  localparam int MUL_BITS   = 20;
  localparam int GOAL_FRAC  = 15;
  localparam int DRIVE_FRAC = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_ANGLE  = 3'd0,
    CFG_MAX_MV        = 3'd1,
    CFG_MIN_MV        = 3'd2,
    CFG_ACCURATE_MODE = 3'd3,
    CFG_GAIN_P        = 3'd4,
    CFG_GAIN_I        = 3'd5,
    CFG_GAIN_D        = 3'd6,
    CFG_TARGET_SCALE  = 3'd7
  } cfg_idx_t;

  localparam logic [MV_W-1:0]    MAX_MV_RST       = 14'd12000;
  localparam logic [GAIN_W-1:0]  GAIN_P_RST       = 20'd40960;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST       = 20'd245760;
  localparam logic [SCALE_W-1:0] TARGET_SCALE_RST = 16'd16320;

  localparam logic [ELAPSED_W-1:0]     TIMEOUT_MS    = 16'd1200;
  localparam logic signed [HEAD_W-1:0] DONE_BAND     = 24'sd256;
  localparam logic signed [HEAD_W-1:0] DONE_BAND_NEG = -24'sd256;

  localparam logic [SUM_W-1:0] GOAL_ROUND  = SUM_W'(64'd1 << (GOAL_FRAC - 1));
  localparam logic [SUM_W-1:0] DRIVE_ROUND = SUM_W'(64'd1 << (DRIVE_FRAC - 1));

endpackage

`default_nettype wire

[hw/rtl/thpid_if.sv]
// Valid/ready channel interfaces for the heading PID regulator.
// Depends on thpid_pkg for the field widths.
`default_nettype none

interface thpid_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     req_type;
  logic signed [thpid_pkg::HEAD_W-1:0]      heading;
  logic        [thpid_pkg::ELAPSED_W-1:0]   elapsed_ms;

  modport source (output valid, req_type, heading, elapsed_ms, input ready);
  modport sink (input valid, req_type, heading, elapsed_ms, output ready);
endinterface

interface thpid_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [thpid_pkg::DRIVE_W-1:0]     drive_mv;
  logic                                     stop_now;
  logic                                     running;

  modport source (output valid, drive_mv, stop_now, running, input ready);
  modport sink (input valid, drive_mv, stop_now, running, output ready);
endinterface

`default_nettype wire

[hw/rtl/turn_heading_pid.sv]
// Heading PID regulator, top level, with a bit-serial shift-add multiplier.
// Depends on thpid_pkg and the channel interfaces in thpid_if.sv.
//
// Usage: configuration registers are written through cfg_we, cfg_index and
// cfg_wdata while the block is idle. Items arrive on in_ch; each produces one
// result on out_ch. A start item records the heading and arms the loop; a
// sample item runs one PID step when armed and returns the left drive in millivolts.
// A start item or an unarmed sample goes from idle straight to the final state;
// an armed sample passes through the prep and multiply states, in fast mode
// after the goal state. A new item can be taken in the cycle after the result
// is registered, so no two items are worked on at once. The shared multiplier
// retires one bit per cycle: 20 gain bits for each of the three terms, plus
// 16 scale bits for the fast-mode target.
// Reset (synchronous, rst_n low) disarms the loop, clears the integral, the
// last error and the start heading, and loads the register defaults.
// The result sits in an output register; if the receiver stalls, the next
// item may still be taken and worked on, and it waits for the transfer of
// the earlier result before its own is registered.
`default_nettype none

module turn_heading_pid (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  thpid_in_if.sink                                 in_ch,
  thpid_out_if.source                              out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [thpid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [thpid_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_GOAL = 5'b00010,
    ST_PREP = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_NONE  = 2'd1,
    KIND_PID   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_t;

  localparam int HW = thpid_pkg::HEAD_W;
  localparam int AW = thpid_pkg::ACC_W;
  localparam int SW = thpid_pkg::SUM_W;
  localparam int DW = SW - thpid_pkg::DRIVE_FRAC;
  localparam int GW = HW + 2;

  // Control and architectural state.
  state_t                                   state_r, state_nxt;
  logic                                     armed_r, armed_nxt;
  logic                                     out_valid_r, out_valid_nxt;
  logic signed [HW-1:0]                     start_r, start_nxt;
  logic signed [AW-1:0]                     acc_r, acc_nxt;
  logic signed [HW-1:0]                     last_r, last_nxt;
  logic [thpid_pkg::CNT_W-1:0]              cnt_r, cnt_nxt;
  term_t                                    term_r, term_nxt;

  // Configuration registers.
  logic signed [HW-1:0]                     target_r, target_nxt;
  logic [thpid_pkg::MV_W-1:0]               max_mv_r, max_mv_nxt;
  logic [thpid_pkg::MV_W-1:0]               min_mv_r, min_mv_nxt;
  logic                                     accurate_r, accurate_nxt;
  logic [thpid_pkg::GAIN_W-1:0]             gain_p_r, gain_p_nxt;
  logic [thpid_pkg::GAIN_W-1:0]             gain_i_r, gain_i_nxt;
  logic [thpid_pkg::GAIN_W-1:0]             gain_d_r, gain_d_nxt;
  logic [thpid_pkg::SCALE_W-1:0]            scale_r, scale_nxt;

  // Datapath registers.
  logic [SW-1:0]                            mcand_r, mcand_nxt;
  logic [thpid_pkg::GAIN_W-1:0]             mplier_r, mplier_nxt;
  logic [SW-1:0]                            sum_r, sum_nxt;
  kind_t                                    kind_r, kind_nxt;
  logic signed [HW-1:0]                     err_r, err_nxt;
  logic signed [HW:0]                       deriv_r, deriv_nxt;
  logic signed [HW-1:0]                     heading_r, heading_nxt;
  logic [thpid_pkg::ELAPSED_W-1:0]          elapsed_r, elapsed_nxt;
  logic signed [thpid_pkg::DRIVE_W-1:0]     out_drive_r, out_drive_nxt;
  logic                                     out_stop_r, out_stop_nxt;
  logic                                     out_run_r, out_run_nxt;

  // Combinational datapath.
  logic                                     in_fire;
  logic                                     out_free;
  logic [SW-1:0]                            sum_step;
  logic signed [GW-1:0]                     goal_w;
  logic signed [HW:0]                       turned_w;
  logic signed [GW:0]                       diff_w;
  logic signed [HW-1:0]                     err_w;
  logic signed [AW:0]                       acc_sum_w;
  logic signed [AW-1:0]                     acc_sat_w;
  logic                                     sign_change_w;
  logic signed [DW-1:0]                     drive_raw_w;
  logic signed [DW-1:0]                     mn_w;
  logic signed [DW-1:0]                     mx_w;
  logic signed [DW-1:0]                     clamped_w;
  logic                                     in_band_w;
  logic                                     stop_w;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign sum_step = sum_r + (mplier_r[0] ? mcand_r : '0);

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.drive_mv = out_drive_r;
  assign out_ch.stop_now = out_stop_r;
  assign out_ch.running  = out_run_r;

  always_comb begin
    goal_w   = accurate_r ? {{2{target_r[HW-1]}}, target_r}
                          : sum_r[GW+thpid_pkg::GOAL_FRAC-1:thpid_pkg::GOAL_FRAC];
    turned_w = {heading_r[HW-1], heading_r} - {start_r[HW-1], start_r};
    diff_w   = {goal_w[GW-1], goal_w} - {{2{turned_w[HW]}}, turned_w};
    if ((diff_w[GW:HW-1] == '0) || (diff_w[GW:HW-1] == '1)) begin
      err_w = diff_w[HW-1:0];
    end else if (diff_w[GW]) begin
      err_w = {1'b1, {(HW-1){1'b0}}};
    end else begin
      err_w = {1'b0, {(HW-1){1'b1}}};
    end
    acc_sum_w = {acc_r[AW-1], acc_r} + {{(AW-HW+1){err_w[HW-1]}}, err_w};
    if (acc_sum_w[AW] == acc_sum_w[AW-1]) begin
      acc_sat_w = acc_sum_w[AW-1:0];
    end else if (acc_sum_w[AW]) begin
      acc_sat_w = {1'b1, {(AW-1){1'b0}}};
    end else begin
      acc_sat_w = {1'b0, {(AW-1){1'b1}}};
    end
    sign_change_w = (err_w[HW-1] != last_r[HW-1]) || ((err_w == '0) != (last_r == '0));
  end

  always_comb begin
    drive_raw_w = sum_r[SW-1:thpid_pkg::DRIVE_FRAC];
    mn_w        = $signed({{(DW-thpid_pkg::MV_W){1'b0}}, min_mv_r});
    mx_w        = $signed({{(DW-thpid_pkg::MV_W){1'b0}}, max_mv_r});
    clamped_w   = drive_raw_w;
    if (drive_raw_w > $signed(DW'(0))) begin
      if (clamped_w < mn_w) begin
        clamped_w = mn_w;
      end
      if (clamped_w > mx_w) begin
        clamped_w = mx_w;
      end
    end else if (drive_raw_w < $signed(DW'(0))) begin
      if (clamped_w > -mn_w) begin
        clamped_w = -mn_w;
      end
      if (clamped_w < -mx_w) begin
        clamped_w = -mx_w;
      end
    end
    in_band_w = (err_r <= thpid_pkg::DONE_BAND)
             && (!accurate_r || (err_r >= thpid_pkg::DONE_BAND_NEG));
    stop_w    = ((clamped_w <= mn_w) && (clamped_w >= -mn_w) && in_band_w)
             || (elapsed_r >= thpid_pkg::TIMEOUT_MS);
  end

  always_comb begin
    state_nxt     = state_r;
    armed_nxt     = armed_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    start_nxt     = start_r;
    acc_nxt       = acc_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    term_nxt      = term_r;
    target_nxt    = target_r;
    max_mv_nxt    = max_mv_r;
    min_mv_nxt    = min_mv_r;
    accurate_nxt  = accurate_r;
    gain_p_nxt    = gain_p_r;
    gain_i_nxt    = gain_i_r;
    gain_d_nxt    = gain_d_r;
    scale_nxt     = scale_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    sum_nxt       = sum_r;
    kind_nxt      = kind_r;
    err_nxt       = err_r;
    deriv_nxt     = deriv_r;
    heading_nxt   = heading_r;
    elapsed_nxt   = elapsed_r;
    out_drive_nxt = out_drive_r;
    out_stop_nxt  = out_stop_r;
    out_run_nxt   = out_run_r;

    if (cfg_we) begin
      unique case (cfg_index)
        thpid_pkg::CFG_TARGET_ANGLE:  target_nxt   = cfg_wdata[HW-1:0];
        thpid_pkg::CFG_MAX_MV:        max_mv_nxt   = cfg_wdata[thpid_pkg::MV_W-1:0];
        thpid_pkg::CFG_MIN_MV:        min_mv_nxt   = cfg_wdata[thpid_pkg::MV_W-1:0];
        thpid_pkg::CFG_ACCURATE_MODE: accurate_nxt = cfg_wdata[0];
        thpid_pkg::CFG_GAIN_P:        gain_p_nxt   = cfg_wdata[thpid_pkg::GAIN_W-1:0];
        thpid_pkg::CFG_GAIN_I:        gain_i_nxt   = cfg_wdata[thpid_pkg::GAIN_W-1:0];
        thpid_pkg::CFG_GAIN_D:        gain_d_nxt   = cfg_wdata[thpid_pkg::GAIN_W-1:0];
        thpid_pkg::CFG_TARGET_SCALE:  scale_nxt    = cfg_wdata[thpid_pkg::SCALE_W-1:0];
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          heading_nxt = in_ch.heading;
          elapsed_nxt = in_ch.elapsed_ms;
          cnt_nxt     = '0;
          mcand_nxt   = {{(SW-HW){target_r[HW-1]}}, target_r};
          mplier_nxt  = {{(thpid_pkg::GAIN_W-thpid_pkg::SCALE_W){1'b0}}, scale_r};
          sum_nxt     = thpid_pkg::GOAL_ROUND;
          if (!in_ch.req_type) begin
            start_nxt = in_ch.heading;
            armed_nxt = 1'b1;
            kind_nxt  = KIND_START;
            state_nxt = ST_FIN;
          end else if (!armed_r) begin
            kind_nxt  = KIND_NONE;
            state_nxt = ST_FIN;
          end else begin
            kind_nxt  = KIND_PID;
            state_nxt = accurate_r ? ST_PREP : ST_GOAL;
          end
        end
      end
      ST_GOAL: begin
        sum_nxt    = sum_step;
        mcand_nxt  = {mcand_r[SW-2:0], 1'b0};
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == thpid_pkg::CNT_W'(thpid_pkg::GOAL_BITS - 1)) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        err_nxt    = err_w;
        deriv_nxt  = {err_w[HW-1], err_w} - {last_r[HW-1], last_r};
        acc_nxt    = sign_change_w ? '0 : acc_sat_w;
        last_nxt   = err_w;
        mcand_nxt  = {{(SW-HW){err_w[HW-1]}}, err_w};
        mplier_nxt = gain_p_r;
        sum_nxt    = thpid_pkg::DRIVE_ROUND;
        cnt_nxt    = '0;
        term_nxt   = TERM_P;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        sum_nxt    = sum_step;
        mcand_nxt  = {mcand_r[SW-2:0], 1'b0};
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == thpid_pkg::CNT_W'(thpid_pkg::MUL_BITS - 1)) begin
          cnt_nxt = '0;
          unique case (term_r)
            TERM_P: begin
              term_nxt   = TERM_I;
              mcand_nxt  = {{(SW-AW){acc_r[AW-1]}}, acc_r};
              mplier_nxt = gain_i_r;
            end
            TERM_I: begin
              term_nxt   = TERM_D;
              mcand_nxt  = {{(SW-HW-1){deriv_r[HW]}}, deriv_r};
              mplier_nxt = gain_d_r;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          unique case (kind_r)
            KIND_START: begin
              out_drive_nxt = '0;
              out_stop_nxt  = 1'b0;
              out_run_nxt   = 1'b1;
            end
            KIND_PID: begin
              out_drive_nxt = stop_w ? '0 : clamped_w[thpid_pkg::DRIVE_W-1:0];
              out_stop_nxt  = stop_w;
              out_run_nxt   = !stop_w;
              if (stop_w) begin
                armed_nxt = 1'b0;
              end
            end
            default: begin
              out_drive_nxt = '0;
              out_stop_nxt  = 1'b0;
              out_run_nxt   = 1'b0;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
      start_r     <= '0;
      acc_r       <= '0;
      last_r      <= '0;
      cnt_r       <= '0;
      term_r      <= TERM_P;
      target_r    <= '0;
      max_mv_r    <= thpid_pkg::MAX_MV_RST;
      min_mv_r    <= '0;
      accurate_r  <= 1'b1;
      gain_p_r    <= thpid_pkg::GAIN_P_RST;
      gain_i_r    <= '0;
      gain_d_r    <= thpid_pkg::GAIN_D_RST;
      scale_r     <= thpid_pkg::TARGET_SCALE_RST;
    end else begin
      state_r     <= state_nxt;
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
      start_r     <= start_nxt;
      acc_r       <= acc_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
      term_r      <= term_nxt;
      target_r    <= target_nxt;
      max_mv_r    <= max_mv_nxt;
      min_mv_r    <= min_mv_nxt;
      accurate_r  <= accurate_nxt;
      gain_p_r    <= gain_p_nxt;
      gain_i_r    <= gain_i_nxt;
      gain_d_r    <= gain_d_nxt;
      scale_r     <= scale_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    sum_r       <= sum_nxt;
    kind_r      <= kind_nxt;
    err_r       <= err_nxt;
    deriv_r     <= deriv_nxt;
    heading_r   <= heading_nxt;
    elapsed_r   <= elapsed_nxt;
    out_drive_r <= out_drive_nxt;
    out_stop_r  <= out_stop_nxt;
    out_run_r   <= out_run_nxt;
  end

  // A result is only registered on leaving the final state.
  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result registered outside the final state");

  // A stopping result brakes and reports the loop as no longer running.
  a_stop_brakes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stop_r) |-> (out_drive_r == '0) && !out_run_r)
    else $error("stopping result with drive or still running");

  // The loop is disarmed only by a stopping result.
  a_disarm_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(armed_r)) |-> (out_valid_r && out_stop_r))
    else $error("loop disarmed without a stopping result");

  // The bit counter never passes the gain width while multiplying.
  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (cnt_r < thpid_pkg::CNT_W'(thpid_pkg::MUL_BITS)))
    else $error("multiplier bit counter out of range");

endmodule

`default_nettype wire

[test/tb_turn_heading_pid.sv]
// Self-checking testbench for the heading PID regulator turn_heading_pid.
// It needs thpid_pkg and the channel interfaces in thpid_if.sv. Its own PID
// model predicts each result, and a scoreboard checks every output transfer.

module tb_turn_heading_pid;
  import thpid_pkg::*;

  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam longint ERR_HI = (64'sd1 <<< (HEAD_W - 1)) - 1;
  localparam longint ERR_LO = -(64'sd1 <<< (HEAD_W - 1));
  localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -(64'sd1 <<< (ACC_W - 1));

  typedef struct {
    logic                     req_type;
    logic signed [HEAD_W-1:0] heading;
    logic [ELAPSED_W-1:0]     elapsed_ms;
  } turn_item_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive_mv;
    logic                      stop_now;
    logic                      running;
  } drive_res_t;

  typedef struct {
    logic signed [HEAD_W-1:0] target;
    logic [MV_W-1:0]          max_mv;
    logic [MV_W-1:0]          min_mv;
    logic                     accurate;
    logic [GAIN_W-1:0]        kp;
    logic [GAIN_W-1:0]        ki;
    logic [GAIN_W-1:0]        kd;
    logic [SCALE_W-1:0]       scale;
  } pid_setting_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  thpid_in_if  in_ch();
  thpid_out_if out_ch();

  turn_heading_pid DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pid_setting_t live_cfg;
  logic signed [HEAD_W-1:0] start_heading;
  logic signed [HEAD_W-1:0] last_err;
  logic signed [ACC_W-1:0]  integral;
  logic                     armed;

  turn_item_t pending_items[$];
  drive_res_t drive_due[$];

  int n_faults;
  int n_queued;
  int n_in;
  int n_out;
  int n_stops;
  int n_settings;
  int n_drains;
  int gap_left;
  int burst_left;
  int rdy_mode;
  int rdy_left;
  logic drain_hold;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic drive_res_t pid_update(turn_item_t it);
    drive_res_t r;
    longint goal, err, acc, deriv, sum, drv, mx, mn;
    logic band_ok, stop;
    r.drive_mv = '0;
    r.stop_now = 1'b0;
    r.running  = 1'b0;
    if (it.req_type == REQ_START) begin
      start_heading = it.heading;
      armed = 1'b1;
      r.running = 1'b1;
      return r;
    end
    if (!armed) return r;

    if (live_cfg.accurate)
      goal = longint'(live_cfg.target);
    else
      goal = (longint'(live_cfg.target) * longint'(live_cfg.scale)
              + (64'sd1 <<< (GOAL_FRAC - 1))) >>> GOAL_FRAC;
    err = goal - (longint'(it.heading) - longint'(start_heading));
    if (err > ERR_HI) err = ERR_HI;
    if (err < ERR_LO) err = ERR_LO;

    acc = longint'(integral) + err;
    if (acc > ACC_HI) acc = ACC_HI;
    if (acc < ACC_LO) acc = ACC_LO;
    if ((err > 0) != (last_err > 0) || (err < 0) != (last_err < 0)) acc = 0;
    deriv = err - longint'(last_err);

    sum = err * longint'(live_cfg.kp) + acc * longint'(live_cfg.ki)
        + deriv * longint'(live_cfg.kd);
    drv = (sum + (64'sd1 <<< (DRIVE_FRAC - 1))) >>> DRIVE_FRAC;

    mx = longint'(live_cfg.max_mv);
    mn = longint'(live_cfg.min_mv);
    if (drv > 0) begin
      if (drv < mn) drv = mn;
      if (drv > mx) drv = mx;
    end else if (drv < 0) begin
      if (drv > -mn) drv = -mn;
      if (drv < -mx) drv = -mx;
    end

    if (live_cfg.accurate)
      band_ok = (err <= longint'(DONE_BAND)) && (err >= -longint'(DONE_BAND));
    else
      band_ok = (err <= longint'(DONE_BAND));
    stop = (drv <= mn && drv >= -mn && band_ok) || (it.elapsed_ms >= TIMEOUT_MS);

    integral = acc[ACC_W-1:0];
    last_err = err[HEAD_W-1:0];
    if (stop) begin
      armed = 1'b0;
      drv = 0;
    end
    r.drive_mv = drv[DRIVE_W-1:0];
    r.stop_now = stop;
    r.running  = armed;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    n_faults++;
    if (n_faults <= 100) $display("mismatch at %0t: %s", $time, what);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    turn_item_t got;
    turn_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
      drain_hold = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        got.req_type   = in_ch.req_type;
        got.heading    = in_ch.heading;
        got.elapsed_ms = in_ch.elapsed_ms;
        drive_due.push_back(pid_update(got));
        n_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (drain_hold && drive_due.size() == 0) drain_hold = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (drain_hold || pending_items.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if ($urandom_range(0, 149) == 0 || (n_drains == 0 && n_in >= 40)) begin
          // Hold off until every outstanding result has been transferred.
          drain_hold = 1'b1;
          n_drains++;
          in_ch.valid <= 1'b0;
        end else begin
          nxt = pending_items.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.req_type   <= nxt.req_type;
          in_ch.heading    <= nxt.heading;
          in_ch.elapsed_ms <= nxt.elapsed_ms;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end
        end
      end
    end
  end

  // Receiver: stall pattern switches between free flow, random and sparse ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rdy_left = 0;
      rdy_mode = 0;
    end else begin
      if (rdy_left == 0) begin
        rdy_mode = $urandom_range(0, 3);
        rdy_left = $urandom_range(16, 300);
      end else begin
        rdy_left--;
      end
      case (rdy_mode)
        0, 1: out_ch.ready <= 1'b1;
        2: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    drive_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_out++;
      if (drive_due.size() == 0) begin
        report_mismatch("result transfer with no result outstanding");
      end else begin
        want = drive_due.pop_front();
        if (want.stop_now) n_stops++;
        if (out_ch.drive_mv !== want.drive_mv)
          report_mismatch($sformatf("drive_mv %0d, expected %0d", out_ch.drive_mv,
                                    want.drive_mv));
        if (out_ch.stop_now !== want.stop_now)
          report_mismatch($sformatf("stop_now %b, expected %b", out_ch.stop_now,
                                    want.stop_now));
        if (out_ch.running !== want.running)
          report_mismatch($sformatf("running %b, expected %b", out_ch.running,
                                    want.running));
      end
    end
  end

  task automatic queue_item(logic req, logic [HEAD_W-1:0] heading,
                            logic [ELAPSED_W-1:0] elapsed);
    turn_item_t it;
    it.req_type   = req;
    it.heading    = heading;
    it.elapsed_ms = elapsed;
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic load_setting(pid_setting_t s);
    write_reg(CFG_TARGET_ANGLE, s.target);
    write_reg(CFG_MAX_MV, CFG_DATA_W'(s.max_mv));
    write_reg(CFG_MIN_MV, CFG_DATA_W'(s.min_mv));
    write_reg(CFG_ACCURATE_MODE, CFG_DATA_W'(s.accurate));
    write_reg(CFG_GAIN_P, CFG_DATA_W'(s.kp));
    write_reg(CFG_GAIN_I, CFG_DATA_W'(s.ki));
    write_reg(CFG_GAIN_D, CFG_DATA_W'(s.kd));
    write_reg(CFG_TARGET_SCALE, CFG_DATA_W'(s.scale));
    @(posedge clk);
    cfg_we <= 1'b0;
    live_cfg = s;
    n_settings++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || drive_due.size() != 0);
  endtask

  function automatic pid_setting_t random_setting(bit extreme);
    pid_setting_t s;
    s.accurate = 1'($urandom_range(0, 1));
    if (extreme) begin
      s.target = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      s.max_mv = $urandom_range(0, 1) ? 14'd12000 : 14'd0;
      s.min_mv = $urandom_range(0, 1) ? 14'd12000 : 14'd0;
      s.kp     = $urandom_range(0, 1) ? '1 : '0;
      s.ki     = $urandom_range(0, 1) ? '1 : '0;
      s.kd     = $urandom_range(0, 1) ? '1 : '0;
      s.scale  = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      s.target = HEAD_W'(int'($urandom_range(0, 92160)) - 46080);
      s.max_mv = MV_W'($urandom_range(0, 12000));
      s.min_mv = MV_W'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 12000 : 1500));
      s.kp     = GAIN_W'($urandom_range(0, (1 << $urandom_range(4, 20)) - 1));
      s.ki     = GAIN_W'($urandom_range(0, (1 << $urandom_range(0, 20)) - 1));
      s.kd     = GAIN_W'($urandom_range(0, (1 << $urandom_range(4, 20)) - 1));
      s.scale  = SCALE_W'($urandom_range(0, 65535));
    end
    return s;
  endfunction

  // One turn: a start, then samples that sweep towards the goal with some over- or
  // undershoot and settle on or near it, with elapsed time rising as in a real loop.
  task automatic queue_turn(int n_samples);
    longint goal_est, turned, h0, t, hd;
    int ov, k;
    bit settle_exact;
    h0 = longint'($urandom_range(0, 184320)) - 92160;
    if (live_cfg.accurate)
      goal_est = longint'(live_cfg.target);
    else
      goal_est = (longint'(live_cfg.target) * longint'(live_cfg.scale)) >>> GOAL_FRAC;
    ov = $urandom_range(70, 130);
    settle_exact = 1'($urandom_range(0, 1));
    t = ($urandom_range(0, 4) == 0) ? $urandom_range(1100, 1199) : $urandom_range(0, 20);
    queue_item(REQ_START, h0[HEAD_W-1:0], ELAPSED_W'($urandom));
    for (k = 1; k <= n_samples; k++) begin
      if (k > n_samples - 3)
        turned = settle_exact ? goal_est : goal_est + longint'($urandom_range(0, 600)) - 300;
      else
        turned = goal_est * k * ov / (n_samples * 100) + longint'($urandom_range(0, 400)) - 200;
      t = t + $urandom_range(1, 45);
      if (t > 65535) t = 65535;
      hd = h0 + turned;
      queue_item(REQ_SAMPLE, hd[HEAD_W-1:0], t[ELAPSED_W-1:0]);
    end
  endtask

  initial begin
    pid_setting_t s;
    int ph, quota;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_TARGET_ANGLE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_START;
    in_ch.heading = '0;
    in_ch.elapsed_ms = '0;
    out_ch.ready = 1'b0;

    live_cfg.target   = '0;
    live_cfg.max_mv   = 14'd12000;
    live_cfg.min_mv   = '0;
    live_cfg.accurate = 1'b1;
    live_cfg.kp       = 20'd40960;
    live_cfg.ki       = '0;
    live_cfg.kd       = 20'd245760;
    live_cfg.scale    = 16'd16320;
    start_heading = '0;
    last_err = '0;
    integral = '0;
    armed = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: unarmed sample, error saturation both ways, settling,
    // the timeout boundary and the largest elapsed time.
    queue_item(REQ_SAMPLE, 24'h000000, 16'd0);
    queue_item(REQ_START, 24'h7FFFFF, 16'hFFFF);
    queue_item(REQ_SAMPLE, 24'h800000, 16'd0);
    queue_item(REQ_SAMPLE, 24'h7FFFFF, 16'd10);
    queue_item(REQ_SAMPLE, 24'h7FFFFF, 16'd20);
    queue_item(REQ_SAMPLE, 24'h7FFFFF, 16'd30);
    queue_item(REQ_START, 24'h800000, 16'd0);
    queue_item(REQ_SAMPLE, 24'h7FFFFF, 16'd1199);
    queue_item(REQ_SAMPLE, 24'h800000, 16'd1200);
    queue_item(REQ_START, 24'h000000, 16'd0);
    queue_item(REQ_SAMPLE, 24'h0003E8, 16'hFFFF);
    queue_item(REQ_START, 24'h000000, 16'd0);
    queue_item(REQ_SAMPLE, 24'h000100, 16'd5);
    wait_idle();

    // Fast mode with the largest target, scale and gains, min above max.
    s.target = 24'h7FFFFF;
    s.max_mv = 14'd500;
    s.min_mv = 14'd12000;
    s.accurate = 1'b0;
    s.kp = '1;
    s.ki = '1;
    s.kd = '1;
    s.scale = '1;
    load_setting(s);
    queue_item(REQ_START, 24'h000000, 16'd0);
    queue_item(REQ_SAMPLE, 24'h000000, 16'd1);
    queue_item(REQ_SAMPLE, 24'h7FFFFF, 16'd2);
    queue_item(REQ_START, 24'h7FFFFF, 16'd0);
    queue_item(REQ_SAMPLE, 24'h800000, 16'd3);
    queue_item(REQ_SAMPLE, 24'h7FFFFF, 16'd4);
    wait_idle();

    // Most negative target, zero scale, minimum equal to maximum.
    s.target = 24'h800000;
    s.max_mv = 14'd12000;
    s.min_mv = 14'd12000;
    s.accurate = 1'b1;
    s.kp = 20'd256;
    s.ki = '1;
    s.kd = '0;
    s.scale = '0;
    load_setting(s);
    queue_item(REQ_START, 24'h000000, 16'd0);
    queue_item(REQ_SAMPLE, 24'h800064, 16'd5);
    queue_item(REQ_START, 24'h000000, 16'd0);
    queue_item(REQ_SAMPLE, 24'h000000, 16'd9);
    queue_item(REQ_SAMPLE, 24'h7FFFFF, 16'd15);
    wait_idle();

    for (ph = 0; ph < 13; ph++) begin
      load_setting(random_setting(ph % 4 == 0));
      quota = n_queued + 110;
      while (n_queued < quota) begin
        if ($urandom_range(0, 5) == 0)
          queue_item($urandom_range(0, 1) ? REQ_SAMPLE : REQ_START, HEAD_W'($urandom),
                     ELAPSED_W'($urandom));
        else
          queue_turn($urandom_range(2, 25));
      end
      wait_idle();
    end

    repeat (120) @(posedge clk);
    $display("Run covered %0d input transfers and %0d results over %0d register settings.",
             n_in, n_out, n_settings);
    $display("Turns stopped %0d times; the sender drained the block %0d times.",
             n_stops, n_drains);
    if (n_faults == 0 && drive_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
